### sv/binary_min_heap_queue_top_macros.svh
// Assertion macros for the binary min-heap queue.
// Used by binary_min_heap_queue_top; they expect signals clk and arst_n in scope.
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define BMHQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BMHQ_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) trig |=> prop) else $error(msg);
`else
`define BMHQ_ASSERT(label, prop, msg)
`define BMHQ_ASSERT_NEXT(label, trig, prop, msg)
`endif

`endif

### sv/bmhq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the binary min-heap queue.
// Used by bmhq_cell and binary_min_heap_queue_top; depends on nothing.
package bmhq_pkg;

	localparam int HEAP_DEPTH_DEF = 32;
	localparam int KEY_W          = 16;
	localparam int COUNT_OUT_W    = 6;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	typedef struct packed {
		logic             action;
		logic [KEY_W-1:0] key_in;
	} cmd_item_t;

	typedef struct packed {
		logic [KEY_W-1:0]       top_key;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic                   is_empty;
		logic                   op_error;
	} rsp_item_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [KEY_W-1:0] key;
	} cell_ctrl_t;

endpackage

### sv/binary_min_heap_queue_top.sv
`timescale 1ns / 1ps
// Each result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the whole cell row
// shifts or inserts together for every push or pop that is not rejected.
// Reset clears the entry count and the result valid flag; cell keys are not cleared.
// Top level of the binary min-heap queue; depends on bmhq_pkg and bmhq_cell.
`include "binary_min_heap_queue_top_macros.svh"
module binary_min_heap_queue_top
	import bmhq_pkg::*;
#(
	parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int CNT_W = $clog2(HEAP_DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;
	rsp_item_t        rsp_d;

	logic             accept;
	logic             is_full;
	logic             err;
	cell_ctrl_t       ctrl;
	logic [KEY_W-1:0] top_d;
	logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

	logic [KEY_W-1:0] cell_key  [HEAP_DEPTH];
	logic             cell_keep [HEAP_DEPTH];
	logic             cell_occ  [HEAP_DEPTH];

	assign cmd_stall = rsp_valid_q && rsp_stall;
	assign accept    = cmd_valid && !cmd_stall;
	assign is_full   = (count_q == CNT_W'(HEAP_DEPTH));
	assign err       = (cmd.action == ACT_PUSH) ? is_full : (count_q == '0);

	always_comb begin
		ctrl.key = cmd.key_in;
		if (!accept || err) begin
			ctrl.op = CELL_HOLD;
		end else if (cmd.action == ACT_PUSH) begin
			ctrl.op = CELL_PUSH;
		end else begin
			ctrl.op = CELL_POP;
		end
	end

	for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
		assign cell_occ[i] = (CNT_W'(i) < count_q);
		if (i == 0) begin : g_first
			bmhq_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.occ       (cell_occ[i]),
				.left_key  (cmd.key_in),
				.left_keep (1'b1),
				.right_key (cell_key[i+1]),
				.key       (cell_key[i]),
				.keep      (cell_keep[i])
			);
		end else if (i == HEAP_DEPTH - 1) begin : g_last
			bmhq_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.occ       (cell_occ[i]),
				.left_key  (cell_key[i-1]),
				.left_keep (cell_keep[i-1]),
				.right_key ('0),
				.key       (cell_key[i]),
				.keep      (cell_keep[i])
			);
		end else begin : g_mid
			bmhq_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.occ       (cell_occ[i]),
				.left_key  (cell_key[i-1]),
				.left_keep (cell_keep[i-1]),
				.right_key (cell_key[i+1]),
				.key       (cell_key[i]),
				.keep      (cell_keep[i])
			);
		end
	end

	always_comb begin
		count_d = count_q;
		top_d   = (count_q == '0) ? '0 : cell_key[0];
		case (ctrl.op)
			CELL_PUSH: begin
				count_d = count_q + CNT_W'(1);
				if (count_q == '0 || cmd.key_in < cell_key[0]) begin
					top_d = cmd.key_in;
				end else begin
					top_d = cell_key[0];
				end
			end
			CELL_POP: begin
				count_d = count_q - CNT_W'(1);
				top_d   = (count_q > CNT_W'(1)) ? cell_key[1] : '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	assign count_ext = {{COUNT_OUT_W{1'b0}}, count_d};

	always_comb begin
		rsp_d.top_key     = top_d;
		rsp_d.entry_count = count_ext[COUNT_OUT_W-1:0];
		rsp_d.is_empty    = (count_d == '0);
		rsp_d.op_error    = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`BMHQ_ASSERT(a_count_bound, count_q <= CNT_W'(HEAP_DEPTH), "entry count beyond depth")
	`BMHQ_ASSERT_NEXT(a_err_hold, accept && err, count_q == $past(count_q), "rejected item changed count")
	`BMHQ_ASSERT(a_empty_flag, rsp_valid |-> (rsp.is_empty == (count_q == '0)), "empty flag mismatch")
	`BMHQ_ASSERT(a_top_key, rsp_valid && !rsp.is_empty |-> rsp.top_key == cell_key[0], "top key mismatch")

endmodule

### sv/bmhq_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted key row: holds one key and trades it with its neighbors.
// Depends on bmhq_pkg.
module bmhq_cell
	import bmhq_pkg::*;
(
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic             occ,
	input  logic [KEY_W-1:0] left_key,
	input  logic             left_keep,
	input  logic [KEY_W-1:0] right_key,
	output logic [KEY_W-1:0] key,
	output logic             keep
);

	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] key_d;

	assign keep = occ && (key_q <= ctrl.key);
	assign key  = key_q;

	always_comb begin
		unique case (ctrl.op)
			CELL_PUSH: begin
				if (keep) begin
					key_d = key_q;
				end else if (left_keep) begin
					key_d = ctrl.key;
				end else begin
					key_d = left_key;
				end
			end
			CELL_POP: begin
				key_d = right_key;
			end
			default: begin
				key_d = key_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

endmodule
